// ----- rtl/atpr_pkg.sv -----
// shared constants, types and tables for the accelerometer tilt core
package atpr_pkg;

    localparam int SAMPLE_BITS_DEF      = 16;
    localparam int FILTER_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STEPS_DEF     = 16;

    localparam int MAX_RED_W   = 30;
    localparam int GUARD_BITS  = 8;
    localparam int CORDIC_HEAD = 12;
    localparam int TABLE_LEN   = 24;
    localparam int ATAN_IDX_W  = $clog2(TABLE_LEN);
    localparam int QUEUE_DEPTH = 2;

    localparam int ANGLE_W = 26;
    localparam int Q8_W    = ANGLE_W - 7;
    localparam int PITCH_W = 16;
    localparam int ROLL_W  = 17;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [Q8_W-1:0]    t_q8;
    typedef logic [ATAN_IDX_W-1:0]     t_atan_idx;

    localparam t_angle HALF_TURN   = 26'sd11796480;
    localparam t_q8    PITCH_LIMIT = 19'sd23040;
    localparam t_q8    ROLL_LIMIT  = 19'sd46080;
    localparam int     ROUND_HALF  = 128;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic t_angle atan_q16(t_atan_idx idx);
        t_angle v;
        case (idx)
            5'd0:    v = 26'sd2949120;
            5'd1:    v = 26'sd1740967;
            5'd2:    v = 26'sd919879;
            5'd3:    v = 26'sd466945;
            5'd4:    v = 26'sd234379;
            5'd5:    v = 26'sd117304;
            5'd6:    v = 26'sd58666;
            5'd7:    v = 26'sd29335;
            5'd8:    v = 26'sd14668;
            5'd9:    v = 26'sd7334;
            5'd10:   v = 26'sd3667;
            5'd11:   v = 26'sd1833;
            5'd12:   v = 26'sd917;
            5'd13:   v = 26'sd458;
            5'd14:   v = 26'sd229;
            5'd15:   v = 26'sd115;
            5'd16:   v = 26'sd57;
            5'd17:   v = 26'sd29;
            5'd18:   v = 26'sd14;
            5'd19:   v = 26'sd7;
            5'd20:   v = 26'sd4;
            5'd21:   v = 26'sd2;
            5'd22:   v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

    // round half up to 8 fraction bits, then clamp to +-lim
    function automatic t_q8 q8_clamp(t_angle a, t_q8 lim);
        logic signed [ANGLE_W:0] sum;
        t_q8 v;
        sum = (ANGLE_W+1)'(a) + (ANGLE_W+1)'(ROUND_HALF);
        v = sum[ANGLE_W:8];
        if (v > lim) begin
            v = lim;
        end
        if (v < -lim) begin
            v = -lim;
        end
        return v;
    endfunction

endpackage

// ----- rtl/atpr_sample_if.sv -----
// request channel carrying one raw three-axis sample
interface atpr_sample_if import atpr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;

    modport source (output valid, output sample_x, output sample_y, output sample_z,
                    input ready);
    modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                    output ready);
endinterface

// ----- rtl/atpr_angle_if.sv -----
// request channel carrying one pitch and roll result
interface atpr_angle_if import atpr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ROLL_W-1:0]  roll_angle;

    modport source (output valid, output pitch_angle, output roll_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

// ----- rtl/accel_tilt_pitch_roll_core.sv -----
// top level: filtered accelerometer sample in, pitch and roll angles out
//
// channel    dir  payload                                 handshake
// i_sample   in   sample_x, sample_y, sample_z (signed)   valid / ready
// o_angle    out  pitch_angle 16b, roll_angle 17b (q8)    valid / ready
//
// the engine handles one request at a time: squares, sum, root with roll cordic, pitch cordic, load
// the root loop (one bit per cycle) overlaps the roll cordic pass
// a held result stalls the next load until o_angle ready is high
// a two-entry queue lets the front take requests while the engine is busy
// synchronous active-low reset clears filter state, queue and control
module accel_tilt_pitch_roll_core import atpr_pkg::*; #(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS     = CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    atpr_sample_if.sink  i_sample,
    atpr_angle_if.source o_angle
);
    localparam int STATE_BITS = SAMPLE_BITS + FILTER_FRAC_BITS;
    localparam int RED_W      = (STATE_BITS > MAX_RED_W) ? MAX_RED_W : STATE_BITS;

    logic                          w_ready;
    logic                          w_full, w_push, w_empty, w_pop;
    logic [3*RED_W-1:0]            w_q_in, w_q_out;
    logic signed [SAMPLE_BITS-1:0] w_sx, w_sy, w_sz;
    logic                          w_out_valid;
    logic signed [PITCH_W-1:0]     w_pitch;
    logic signed [ROLL_W-1:0]      w_roll;

    assign w_sx = SAMPLE_BITS'(i_sample.sample_x);
    assign w_sy = SAMPLE_BITS'(i_sample.sample_y);
    assign w_sz = SAMPLE_BITS'(i_sample.sample_z);
    assign i_sample.ready = w_ready;

    atpr_front #(
        .SAMPLE_BITS      (SAMPLE_BITS),
        .FILTER_FRAC_BITS (FILTER_FRAC_BITS),
        .RED_W            (RED_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_sample.valid),
        .o_ready    (w_ready),
        .i_sample_x (w_sx),
        .i_sample_y (w_sy),
        .i_sample_z (w_sz),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_data     (w_q_in)
    );

    atpr_queue #(
        .DATA_W (3 * RED_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_empty (w_empty)
    );

    atpr_back #(
        .RED_W        (RED_W),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .i_data      (w_q_out),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_angle.ready),
        .o_pitch     (w_pitch),
        .o_roll      (w_roll)
    );

    assign o_angle.valid       = w_out_valid;
    assign o_angle.pitch_angle = w_pitch;
    assign o_angle.roll_angle  = w_roll;

endmodule

// ----- rtl/atpr_front.sv -----
// front end: sample intake, low-pass filter state and range reduction
module atpr_front import atpr_pkg::*; #(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int FILTER_FRAC_BITS = FILTER_FRAC_BITS_DEF,
    parameter int RED_W            = MAX_RED_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_y,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_z,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [3*RED_W-1:0]            o_data
);
    localparam int STATE_BITS = SAMPLE_BITS + FILTER_FRAC_BITS;
    localparam int REDUCE     = STATE_BITS - RED_W;

    logic signed [STATE_BITS-1:0] r_filt_x, r_filt_y, r_filt_z;
    logic signed [STATE_BITS-1:0] n_filt_x, n_filt_y, n_filt_z;
    logic signed [STATE_BITS:0]   w_sum_x, w_sum_y, w_sum_z;
    logic signed [STATE_BITS-1:0] w_sh_x, w_sh_y, w_sh_z;
    logic                         w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept;

    assign w_sum_x = ((STATE_BITS+1)'(i_sample_x) <<< FILTER_FRAC_BITS)
                   + (STATE_BITS+1)'(r_filt_x);
    assign w_sum_y = ((STATE_BITS+1)'(i_sample_y) <<< FILTER_FRAC_BITS)
                   + (STATE_BITS+1)'(r_filt_y);
    assign w_sum_z = ((STATE_BITS+1)'(i_sample_z) <<< FILTER_FRAC_BITS)
                   + (STATE_BITS+1)'(r_filt_z);

    always_comb begin
        n_filt_x = r_filt_x;
        n_filt_y = r_filt_y;
        n_filt_z = r_filt_z;
        if (w_accept) begin
            n_filt_x = w_sum_x[STATE_BITS:1];
            n_filt_y = w_sum_y[STATE_BITS:1];
            n_filt_z = w_sum_z[STATE_BITS:1];
        end
    end

    assign w_sh_x = n_filt_x >>> REDUCE;
    assign w_sh_y = n_filt_y >>> REDUCE;
    assign w_sh_z = n_filt_z >>> REDUCE;
    assign o_data = {w_sh_x[RED_W-1:0], w_sh_y[RED_W-1:0], w_sh_z[RED_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_x <= '0;
            r_filt_y <= '0;
            r_filt_z <= '0;
        end else begin
            r_filt_x <= n_filt_x;
            r_filt_y <= n_filt_y;
            r_filt_z <= n_filt_z;
        end
    end

endmodule

// ----- rtl/atpr_queue.sv -----
// short queue between front end and angle engine
module atpr_queue import atpr_pkg::*; #(
    parameter int DATA_W = 3 * MAX_RED_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
        end
        if (i_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

// ----- rtl/atpr_isqrt.sv -----
// iterative integer square root, one result bit per cycle
module atpr_isqrt import atpr_pkg::*; #(
    parameter int RED_W = MAX_RED_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2*RED_W-1:0] i_value,
    output logic               o_done,
    output logic [RED_W-1:0]   o_root
);
    localparam int IN_W = 2 * RED_W;

    logic [IN_W-1:0] r_rem, r_res, r_bit, n_rem, n_res, n_bit;
    logic            r_busy, r_done, n_busy, n_done;
    logic [IN_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;
    assign o_done  = r_done;
    assign o_root  = r_res[RED_W-1:0];

    always_comb begin
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = i_value;
            n_res  = '0;
            n_bit  = IN_W'(1) << (IN_W - 2);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_rem >= w_trial) begin
                n_rem = r_rem - w_trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit == IN_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

endmodule

// ----- rtl/atpr_cordic.sv -----
// vectoring cordic, one micro-rotation per cycle, angle in degrees q16
module atpr_cordic import atpr_pkg::*; #(
    parameter int RED_W        = MAX_RED_W,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [RED_W:0] i_a,
    input  logic signed [RED_W:0] i_b,
    output logic                  o_done,
    output t_angle                o_angle
);
    localparam int CW    = RED_W + CORDIC_HEAD;
    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic signed [CW-1:0] r_a, r_b, n_a, n_b;
    logic signed [CW-1:0] w_da, w_db;
    t_angle               r_ang, n_ang;
    t_atan_idx            r_idx, n_idx;
    logic                 r_busy, r_done, n_busy, n_done;

    assign w_da    = r_b >>> r_idx;
    assign w_db    = r_a >>> r_idx;
    assign o_done  = r_done;
    assign o_angle = r_ang;

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_ang  = r_ang;
        n_idx  = r_idx;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_a    = CW'(i_a) <<< GUARD_BITS;
            n_b    = CW'(i_b) <<< GUARD_BITS;
            n_ang  = '0;
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!r_b[CW-1]) begin
                n_a   = r_a + w_da;
                n_b   = r_b - w_db;
                n_ang = r_ang + atan_q16(r_idx);
            end else begin
                n_a   = r_a - w_da;
                n_b   = r_b + w_db;
                n_ang = r_ang - atan_q16(r_idx);
            end
            n_idx = r_idx + ATAN_IDX_W'(1);
            if (r_idx == ATAN_IDX_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_ang <= n_ang;
        r_idx <= n_idx;
    end

endmodule

// ----- rtl/atpr_back.sv -----
// angle engine: squares, root, roll and pitch cordic passes, result register
module atpr_back import atpr_pkg::*; #(
    parameter int RED_W        = MAX_RED_W,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_empty,
    output logic                      o_pop,
    input  logic [3*RED_W-1:0]        i_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [PITCH_W-1:0] o_pitch,
    output logic signed [ROLL_W-1:0]  o_roll
);
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SQUARE = 6'b000010,
        S_SUM    = 6'b000100,
        S_RUN    = 6'b001000,
        S_PITCH  = 6'b010000,
        S_LOAD   = 6'b100000
    } t_back_state;

    t_back_state r_state, n_state;

    logic signed [RED_W-1:0]   r_x, r_y, r_z, n_x, n_y, n_z;
    logic [2*RED_W-1:0]        r_yy, r_zz, n_yy, n_zz;
    logic [RED_W-1:0]          r_root, n_root;
    t_angle                    r_roll_q16, n_roll_q16, r_pitch_q16, n_pitch_q16;
    logic                      r_roll_done, n_roll_done, r_root_done, n_root_done;
    logic                      r_out_valid, n_out_valid;
    logic signed [PITCH_W-1:0] r_pitch_out, n_pitch_out;
    logic signed [ROLL_W-1:0]  r_roll_out, n_roll_out;

    logic signed [2*RED_W-1:0] w_yy, w_zz;
    logic signed [RED_W:0]     w_y_ext, w_z_ext, w_a, w_b;
    logic                      w_cordic_start, w_cordic_done, w_sqrt_done;
    t_angle                    w_cordic_angle, w_pitch_q16_in;
    logic [RED_W-1:0]          w_root;
    logic                      w_roll_zero, w_pitch_zero, w_y_nonpos, w_load;
    t_q8                       w_pitch_q8, w_roll_q8;

    assign w_yy    = r_y * r_y;
    assign w_zz    = r_z * r_z;
    assign w_y_ext = (RED_W+1)'(r_y);
    assign w_z_ext = (RED_W+1)'(r_z);

    assign w_roll_zero  = (r_y == '0) && (r_z == '0);
    assign w_pitch_zero = (r_x == '0) && (r_root == '0);
    assign w_y_nonpos   = r_y[RED_W-1] || (r_y == '0);

    assign w_cordic_start = (r_state == S_SUM)
                         || ((r_state == S_RUN) && r_roll_done && r_root_done);

    always_comb begin
        if (r_state == S_SUM) begin
            w_a = r_z[RED_W-1] ? -w_z_ext : w_z_ext;
            w_b = r_z[RED_W-1] ? w_y_ext : -w_y_ext;
        end else begin
            w_a = {1'b0, r_root};
            w_b = (RED_W+1)'(r_x);
        end
    end

    atpr_isqrt #(
        .RED_W (RED_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SUM),
        .i_value (r_yy + r_zz),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    atpr_cordic #(
        .RED_W        (RED_W),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_cordic_done),
        .o_angle (w_cordic_angle)
    );

    assign w_pitch_q16_in = w_pitch_zero ? '0 : w_cordic_angle;
    assign w_pitch_q8     = q8_clamp(r_pitch_q16, PITCH_LIMIT);
    assign w_roll_q8      = q8_clamp(r_roll_q16, ROLL_LIMIT);
    assign w_load         = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_pitch     = r_pitch_out;
    assign o_roll      = r_roll_out;

    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_yy        = r_yy;
        n_zz        = r_zz;
        n_root      = r_root;
        n_roll_q16  = r_roll_q16;
        n_pitch_q16 = r_pitch_q16;
        n_roll_done = r_roll_done;
        n_root_done = r_root_done;
        n_out_valid = r_out_valid && !i_out_ready;
        n_pitch_out = r_pitch_out;
        n_roll_out  = r_roll_out;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_x     = i_data[3*RED_W-1:2*RED_W];
                    n_y     = i_data[2*RED_W-1:RED_W];
                    n_z     = i_data[RED_W-1:0];
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: begin
                n_yy    = w_yy;
                n_zz    = w_zz;
                n_state = S_SUM;
            end
            S_SUM: begin
                n_roll_done = 1'b0;
                n_root_done = 1'b0;
                n_state     = S_RUN;
            end
            S_RUN: begin
                if (w_cordic_done) begin
                    n_roll_done = 1'b1;
                    if (w_roll_zero) begin
                        n_roll_q16 = '0;
                    end else if (!r_z[RED_W-1]) begin
                        n_roll_q16 = w_cordic_angle;
                    end else if (w_y_nonpos) begin
                        n_roll_q16 = w_cordic_angle + HALF_TURN;
                    end else begin
                        n_roll_q16 = w_cordic_angle - HALF_TURN;
                    end
                end
                if (w_sqrt_done) begin
                    n_root_done = 1'b1;
                    n_root      = w_root;
                end
                if (r_roll_done && r_root_done) begin
                    n_state = S_PITCH;
                end
            end
            S_PITCH: begin
                if (w_cordic_done) begin
                    n_pitch_q16 = w_pitch_q16_in;
                    n_state     = S_LOAD;
                end
            end
            S_LOAD: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_pitch_out = w_pitch_q8[PITCH_W-1:0];
                    n_roll_out  = w_roll_q8[ROLL_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_roll_done <= 1'b0;
            r_root_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_roll_done <= n_roll_done;
            r_root_done <= n_root_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_yy        <= n_yy;
        r_zz        <= n_zz;
        r_root      <= n_root;
        r_roll_q16  <= n_roll_q16;
        r_pitch_q16 <= n_pitch_q16;
        r_pitch_out <= n_pitch_out;
        r_roll_out  <= n_roll_out;
    end

    a_cordic_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == S_RUN || r_state == S_PITCH))
        else $error("cordic finished outside an angle phase");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("result load did not raise valid");

endmodule

// ----- tb/sv/tb_accel_tilt_pitch_roll_core.sv -----
// testbench for the accelerometer tilt core: low-pass filtered samples in, pitch and roll out
`timescale 1ns / 100ps

module tb_accel_tilt_pitch_roll_core import atpr_pkg::*;;

    localparam int     CLK_HALF    = 6;
    localparam int     RST_CYCLES  = 9;
    localparam int     SMP_W       = SAMPLE_BITS_DEF;
    localparam int     FRAC_W      = FILTER_FRAC_BITS_DEF;
    localparam int     STATE_W     = SMP_W + FRAC_W;
    localparam int     STATE_SHIFT = (STATE_W > MAX_RED_W) ? STATE_W - MAX_RED_W : 0;
    localparam int     CORDIC_ITER = (CORDIC_STEPS_DEF > TABLE_LEN) ? TABLE_LEN
                                                                    : CORDIC_STEPS_DEF;
    localparam longint HALF_TURN_Q16 = 64'sd11796480;
    localparam longint PITCH_MAX     = 64'sd23040;
    localparam longint ROLL_MAX      = 64'sd46080;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = 150;

    localparam longint ATAN_DEG_Q16 [0:TABLE_LEN-1] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef logic signed [SMP_W-1:0] t_sample;

    typedef struct {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ROLL_W-1:0]  roll;
    } t_tilt;

    logic i_clk;
    logic i_rst_n;

    atpr_sample_if s_if ();
    atpr_angle_if  a_if ();

    accel_tilt_pitch_roll_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(s_if),
        .o_angle (a_if)
    );

    longint filt_x;
    longint filt_y;
    longint filt_z;
    t_tilt  tilt_expect_q[$];
    int     err_count;
    int     samples_sent;
    int     angles_seen;
    bit     idle_on;
    int     ready_hold;

    initial i_clk = 1'b0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic longint root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= res + probe) begin
                n   = n - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring rotation, a >= 0, angle in degrees q16
    function automatic longint cordic_angle(longint a, longint b);
        longint ang;
        longint da;
        longint db;
        ang = 0;
        a   = a * (64'sd1 <<< GUARD_BITS);
        b   = b * (64'sd1 <<< GUARD_BITS);
        for (int i = 0; i < CORDIC_ITER; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a   = a + da;
                b   = b - db;
                ang = ang + ATAN_DEG_Q16[i];
            end else begin
                a   = a - da;
                b   = b + db;
                ang = ang - ATAN_DEG_Q16[i];
            end
        end
        return ang;
    endfunction

    function automatic longint atan2_deg_q16(longint num, longint den);
        if (num == 0 && den == 0) begin
            return 0;
        end
        if (den >= 0) begin
            return cordic_angle(den, num);
        end
        if (num >= 0) begin
            return cordic_angle(-den, -num) + HALF_TURN_Q16;
        end
        return cordic_angle(-den, -num) - HALF_TURN_Q16;
    endfunction

    function automatic longint q8_limit(longint q16, longint lim);
        longint v;
        v = (q16 + ROUND_HALF) >>> 8;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    // advance the filter and queue the angles it gives
    function automatic void predict_tilt(t_sample sx, t_sample sy, t_sample sz);
        longint x;
        longint y;
        longint z;
        longint mag;
        t_tilt  t;
        filt_x = ((longint'(sx) <<< FRAC_W) + filt_x) >>> 1;
        filt_y = ((longint'(sy) <<< FRAC_W) + filt_y) >>> 1;
        filt_z = ((longint'(sz) <<< FRAC_W) + filt_z) >>> 1;
        x = filt_x >>> STATE_SHIFT;
        y = filt_y >>> STATE_SHIFT;
        z = filt_z >>> STATE_SHIFT;
        mag = root_floor(longint'(y * y) + longint'(z * z));
        t.pitch = PITCH_W'(q8_limit(atan2_deg_q16(x, mag), PITCH_MAX));
        t.roll  = ROLL_W'(q8_limit(atan2_deg_q16(-y, z), ROLL_MAX));
        tilt_expect_q = {tilt_expect_q, t};
    endfunction

    task automatic send_sample(t_sample sx, t_sample sy, t_sample sz);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_if.valid    <= 1'b1;
        s_if.sample_x <= sx;
        s_if.sample_y <= sy;
        s_if.sample_z <= sz;
        do @(posedge i_clk); while (!s_if.ready);
        predict_tilt(sx, sy, sz);
        samples_sent++;
    endtask

    function automatic t_sample rand_axis();
        t_sample r;
        r = t_sample'($urandom());
        return r >>> $urandom_range(0, SMP_W - 1);
    endfunction

    function automatic t_sample jitter(t_sample v, int amp);
        return t_sample'(int'(v) + $urandom_range(0, 2 * amp) - amp);
    endfunction

    always @(posedge i_clk) begin
        t_tilt t;
        if (i_rst_n && a_if.valid && a_if.ready) begin
            angles_seen++;
            if (tilt_expect_q.size() == 0) begin
                $error("unexpected angle result: pitch %0d roll %0d",
                       a_if.pitch_angle, a_if.roll_angle);
                err_count++;
            end else begin
                t = tilt_expect_q.pop_front();
                if (a_if.pitch_angle !== t.pitch) begin
                    $error("pitch_angle mismatch: expected %0d, got %0d",
                           t.pitch, a_if.pitch_angle);
                    err_count++;
                end
                if (a_if.roll_angle !== t.roll) begin
                    $error("roll_angle mismatch: expected %0d, got %0d",
                           t.roll, a_if.roll_angle);
                    err_count++;
                end
            end
        end
    end

    initial begin
        a_if.ready <= 1'b0;
        ready_hold = 0;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                a_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                ready_hold = $urandom_range(1, 6) - 1;
                a_if.ready <= 1'b0;
            end else begin
                a_if.ready <= 1'b1;
            end
        end
    end

    // zero vector on both angles right after reset
    task automatic test_zero_vector();
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
    endtask

    // pitch at the vertical with no y or z component
    task automatic test_pitch_vertical();
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
    endtask

    // negative z: -y zero gives the positive half turn, then both signs of y
    task automatic test_roll_half_turn();
        send_sample(16'sd0, 16'sd0, -16'sd1000);
        send_sample(16'sd0, 16'sd0, 16'sh8000);
        send_sample(16'sd300, 16'sd2000, 16'sh8000);
        send_sample(-16'sd300, -16'sd4000, 16'sh8000);
        send_sample(16'sd0, 16'sd5000, 16'sd0);
    endtask

    task automatic test_field_extremes();
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd1, 16'sd1);
    endtask

    // mostly steady vectors with jitter so the filter settles, plus noise, repeated sparse vectors and near-zero jitter
    task automatic test_random_sequences(int n_items);
        int      done;
        int      mode;
        int      run;
        t_sample bx;
        t_sample by;
        t_sample bz;
        done = 0;
        while (done < n_items) begin
            idle_on = ($urandom_range(0, 5) != 0);
            mode    = $urandom_range(0, 9);
            if (mode <= 5) begin
                bx  = rand_axis();
                by  = rand_axis();
                bz  = rand_axis();
                run = $urandom_range(2, 8);
                repeat (run) begin
                    send_sample(jitter(bx, 8), jitter(by, 8), jitter(bz, 8));
                end
                done += run;
            end else if (mode <= 7) begin
                send_sample(t_sample'($urandom()), t_sample'($urandom()),
                            t_sample'($urandom()));
                done++;
            end else if (mode == 8) begin
                bx = ($urandom_range(0, 1) != 0) ? rand_axis() : t_sample'(0);
                by = ($urandom_range(0, 1) != 0) ? rand_axis() : t_sample'(0);
                bz = ($urandom_range(0, 1) != 0) ? rand_axis() : t_sample'(0);
                repeat (3) send_sample(bx, by, bz);
                done += 3;
            end else begin
                send_sample(jitter(16'sd0, 4), jitter(16'sd0, 4), jitter(16'sd0, 4));
                done++;
            end
        end
    endtask

    // back to back requests with the result side ready once any pending ready hold has run out
    task automatic test_full_rate(int n_items);
        idle_on = 1'b0;
        repeat (n_items) begin
            if ($urandom_range(0, 1) != 0) begin
                send_sample(t_sample'($urandom()), t_sample'($urandom()),
                            t_sample'($urandom()));
            end else begin
                send_sample(rand_axis(), rand_axis(), rand_axis());
            end
        end
    endtask

    initial begin
        int guard;
        err_count    = 0;
        samples_sent = 0;
        angles_seen  = 0;
        filt_x       = 0;
        filt_y       = 0;
        filt_z       = 0;
        idle_on      = 1'b1;
        i_rst_n       <= 1'b0;
        s_if.valid    <= 1'b0;
        s_if.sample_x <= '0;
        s_if.sample_y <= '0;
        s_if.sample_z <= '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_vector();
        test_pitch_vertical();
        test_roll_half_turn();
        test_field_extremes();
        test_random_sequences(880);
        test_full_rate(120);
        s_if.valid <= 1'b0;

        guard = 0;
        while (tilt_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tilt_expect_q.size() != 0) begin
            $error("%0d angle results never arrived", tilt_expect_q.size());
            err_count++;
        end

        $display("sent %0d samples, checked %0d pitch/roll results", samples_sent,
                 angles_seen);
        $display("zero vector, vertical pitch, roll half turn, axis extremes, settled runs");
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- accel_tilt_pitch_roll_core.f -----
rtl/atpr_pkg.sv
rtl/atpr_sample_if.sv
rtl/atpr_angle_if.sv
rtl/atpr_front.sv
rtl/atpr_queue.sv
rtl/atpr_isqrt.sv
rtl/atpr_cordic.sv
rtl/atpr_back.sv
rtl/accel_tilt_pitch_roll_core.sv
tb/sv/tb_accel_tilt_pitch_roll_core.sv
